// ----- rtl/core/double_ended_queue_assert.svh -----
// assertion macros for the double ended queue
// expects clk and rst_n in the scope of each use
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define DQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dq_pkg.sv -----
// shared types and constants for the double ended queue
// no dependencies
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STS_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/dq_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dq_ctrl.sv -----
// sequencing state machine for the double ended queue
// depends on dq_pkg
`default_nettype none

module dq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output dq_pkg::ctrl_t      ctrl
);
  import dq_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: begin
        state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    ctrl.load = 1'b0;
    ctrl.exec = 1'b0;
    ctrl.resp = 1'b0;
    case (state_r)
      ST_IDLE: ctrl.load = accept;
      ST_EXEC: begin
        busy      = 1'b1;
        ctrl.exec = 1'b1;
      end
      ST_RESP: begin
        ctrl.resp = 1'b1;
        ctrl.load = accept;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/dq_datapath.sv -----
// ring pointers, slot store and result registers of the double ended queue
// depends on dq_pkg and dq_ram
`default_nettype none

module dq_datapath #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dq_pkg::ctrl_t                  ctrl,
  input  wire logic [dq_pkg::CMD_W-1:0]       in_command,
  input  wire logic signed [dq_pkg::DATA_W-1:0] in_push_value,
  output logic signed [dq_pkg::DATA_W-1:0]    out_read_value,
  output logic [dq_pkg::STS_W-1:0]            out_status,
  output logic [$clog2(DEPTH+1)-1:0]          out_occupancy
);
  import dq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STS_W-1:0]  status_r, status_nxt;
  logic [CNT_W-1:0]  occ_r;
  logic              use_ram_r, use_ram_nxt;
  logic              empty_r;
  logic [IDX_W-1:0]  head_prev, head_next, tail_prev, tail_next;
  logic              full, empty;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] rdata;

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign head_prev = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign head_next = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;
  assign tail_next = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    status_nxt  = STS_OK;
    use_ram_nxt = 1'b0;
    we          = 1'b0;
    waddr       = tail_r;
    raddr       = head_r;
    case (cmd_r)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_nxt = STS_FULL;
        end else begin
          we        = 1'b1;
          waddr     = head_prev;
          head_nxt  = head_prev;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (full) begin
          status_nxt = STS_FULL;
        end else begin
          we        = 1'b1;
          waddr     = tail_r;
          tail_nxt  = tail_next;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end else begin
          use_ram_nxt = 1'b1;
          raddr       = head_r;
          head_nxt    = head_next;
          count_nxt   = count_r - 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end else begin
          use_ram_nxt = 1'b1;
          raddr       = tail_prev;
          tail_nxt    = tail_prev;
          count_nxt   = count_r - 1'b1;
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end else begin
          use_ram_nxt = 1'b1;
          raddr       = head_r;
        end
      end
      CMD_PEEK_REAR: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end else begin
          use_ram_nxt = 1'b1;
          raddr       = tail_prev;
        end
      end
      default: ;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_command;
      val_r <= in_push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (ctrl.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status_r  <= status_nxt;
      occ_r     <= count_nxt;
      use_ram_r <= use_ram_nxt;
      empty_r   <= (status_nxt == STS_EMPTY);
    end
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we && ctrl.exec),
    .waddr   (waddr),
    .wdata   (val_r),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  assign out_read_value = use_ram_r ? rdata : (empty_r ? '1 : '0);
  assign out_status     = status_r;
  assign out_occupancy  = occ_r;

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue.sv -----
// top level of the double ended queue: controller, datapath and checks
// depends on dq_pkg, dq_ctrl, dq_datapath and double_ended_queue_assert.svh
//
// usage
//   a request is taken at a rising edge with start high and busy low; it
//   carries in_command and in_push_value (ignored for non-push commands)
//   each request gives exactly one result, shown for one cycle with
//   out_valid high on out_read_value, out_status and out_occupancy
//   sequence: the accepting edge moves the controller to ST_EXEC, which
//   executes the request; ST_RESP follows and shows the result
//   the slot ram read is registered, so ST_EXEC updates the pointers and
//   addresses the ram and ST_RESP presents its data; no request is taken
//   in ST_EXEC (busy high), but a new request may be taken in the
//   cycle the result is shown
//   the receiver cannot stall: a result is gone after its one cycle
//   reset (rst_n low, synchronous) empties the queue and drops any request
//   in flight; the slot ram is not cleared, only written slots are read
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [dq_pkg::CMD_W-1:0]         in_command,
  input  wire logic signed [dq_pkg::DATA_W-1:0] in_push_value,
  output logic                                  out_valid,
  output logic signed [dq_pkg::DATA_W-1:0]      out_read_value,
  output logic [dq_pkg::STS_W-1:0]              out_status,
  output logic [$clog2(DEPTH+1)-1:0]            out_occupancy
);
  import dq_pkg::*;

  ctrl_t ctrl;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_command     (in_command),
    .in_push_value  (in_push_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy)
  );

  assign out_valid = ctrl.resp;

`include "double_ended_queue_assert.svh"

  `DQ_ASSERT_NXT(a_accept_busy, start && !busy, busy && !out_valid, "accept not followed by busy")
  `DQ_ASSERT_IMP(a_latency, start && !busy, ##2 out_valid, "result missing two cycles after accept")
  `DQ_ASSERT_NXT(a_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `DQ_ASSERT_IMP(a_occ_bound, out_valid, out_occupancy <= DEPTH, "occupancy beyond depth")

endmodule

`default_nettype wire
